[hdl/manchester_ir_frame_decoder_top_defines.svh]
// Assertion macros shared by the Manchester IR frame decoder.
`ifndef MANCHESTER_IR_FRAME_DECODER_TOP_DEFINES_SVH
`define MANCHESTER_IR_FRAME_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define MIRFD_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mirfd: implication check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define MIRFD_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mirfd: next-cycle check failed");

`endif

[hdl/mirfd_pkg.sv]
// Types, constants and register codes for the Manchester IR frame decoder.
package mirfd_pkg;

	localparam int ADDRESS_BITS = 3;
	localparam int COMMAND_BITS = 3;
	localparam int SAMPLE_BITS  = 10;

	localparam int START_BITS  = 2;
	localparam int FRAME_TOTAL = START_BITS + ADDRESS_BITS + COMMAND_BITS;
	localparam int POS_W       = $clog2(FRAME_TOTAL + 1);
	localparam int FB_W        = (ADDRESS_BITS > COMMAND_BITS) ? ADDRESS_BITS : COMMAND_BITS;

	localparam int NUM_BUTTONS = 3;
	localparam int SEG_W       = 7;
	localparam int BTN_W       = 2;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = SAMPLE_BITS;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BUTTON1     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BUTTON2     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BUTTON3     = 3'd4;

	localparam logic [SAMPLE_BITS-1:0]  THRESHOLD_RST   = SAMPLE_BITS'(511);
	localparam logic [ADDRESS_BITS-1:0] OWN_ADDRESS_RST = ADDRESS_BITS'(1);
	localparam logic [COMMAND_BITS-1:0] BUTTON1_RST     = COMMAND_BITS'(1);
	localparam logic [COMMAND_BITS-1:0] BUTTON2_RST     = COMMAND_BITS'(2);
	localparam logic [COMMAND_BITS-1:0] BUTTON3_RST     = COMMAND_BITS'(4);

	localparam logic [SEG_W-1:0] SEG_NONE = 7'h71;
	localparam logic [NUM_BUTTONS-1:0][SEG_W-1:0] SEG_DIGIT = {7'h4F, 7'h5B, 7'h06};
	localparam logic [BTN_W-1:0] BTN_NONE = 2'd0;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [COMMAND_BITS-1:0] cmd_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0]                     threshold;
		logic [ADDRESS_BITS-1:0]                    own_address;
		logic [NUM_BUTTONS-1:0][COMMAND_BITS-1:0]   button_code;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[hdl/mirfd_if.sv]
// Valid/ready channels for converter samples and decoded button results.
interface mirfd_sample_if;
	logic                                valid;
	logic                                ready;
	logic [mirfd_pkg::SAMPLE_BITS-1:0]  sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface mirfd_result_if;
	logic                          valid;
	logic                          ready;
	logic [mirfd_pkg::SEG_W-1:0]  segments;
	logic [mirfd_pkg::BTN_W-1:0]  button;

	modport source (output valid, output segments, output button, input ready);
	modport sink   (input valid, input segments, input button, output ready);
endinterface

[hdl/manchester_ir_frame_decoder_top.sv]
// Top level of the Manchester IR frame decoder: registers, front, queue, back.
//
// The samples channel takes one converter reading per half-bit period, one
// transaction per reading. A reading below the threshold register counts as
// IR on; a reading equal to it counts as off. A frame is two start bits of
// one, the address bits and the command bits, each bit sent as two halves.
// A frame with a bit error, a bad start bit or a foreign address is dropped
// without any result.
// The results channel carries one transaction per complete frame: the
// seven-segment pattern and the button number (1 to 3), or the 'F' pattern
// with button 0 when the command matches no button code.
// Throughput is one sample per clock cycle while the queue is not full. The
// command of a frame goes into the queue with the transaction that carried
// its last half-bit; the back pops it and registers the lookup as result.
// A two-entry command queue sits between front and back. When the receiver
// stalls, the back holds its result, the queue fills, and only once the
// queue is full does samples.ready drop; nothing is lost.
// Configuration writes go through cfg_we, cfg_index and cfg_wdata and are
// meant to happen while the block is idle. Asynchronous reset clears the
// frame tracker, the queue and the result stage and loads register defaults.
`include "manchester_ir_frame_decoder_top_defines.svh"

module manchester_ir_frame_decoder_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mirfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mirfd_pkg::CFG_W-1:0]      cfg_wdata,
	mirfd_sample_if.sink                     samples,
	mirfd_result_if.source                   results
);

	mirfd_pkg::cfg_t       cfg_q;
	mirfd_pkg::q_status_t  q_status;
	logic                  push;
	mirfd_pkg::cmd_t       push_cmd;
	logic                  pop;
	mirfd_pkg::cmd_t       pop_cmd;

	// Configuration registers; writes to unused indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold      <= mirfd_pkg::THRESHOLD_RST;
			cfg_q.own_address    <= mirfd_pkg::OWN_ADDRESS_RST;
			cfg_q.button_code[0] <= mirfd_pkg::BUTTON1_RST;
			cfg_q.button_code[1] <= mirfd_pkg::BUTTON2_RST;
			cfg_q.button_code[2] <= mirfd_pkg::BUTTON3_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mirfd_pkg::CFG_THRESHOLD: begin
					cfg_q.threshold <= cfg_wdata[mirfd_pkg::SAMPLE_BITS-1:0];
				end
				mirfd_pkg::CFG_OWN_ADDRESS: begin
					cfg_q.own_address <= cfg_wdata[mirfd_pkg::ADDRESS_BITS-1:0];
				end
				mirfd_pkg::CFG_BUTTON1: begin
					cfg_q.button_code[0] <= cfg_wdata[mirfd_pkg::COMMAND_BITS-1:0];
				end
				mirfd_pkg::CFG_BUTTON2: begin
					cfg_q.button_code[1] <= cfg_wdata[mirfd_pkg::COMMAND_BITS-1:0];
				end
				mirfd_pkg::CFG_BUTTON3: begin
					cfg_q.button_code[2] <= cfg_wdata[mirfd_pkg::COMMAND_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	mirfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_status (q_status),
		.samples  (samples),
		.push     (push),
		.push_cmd (push_cmd)
	);

	mirfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.status   (q_status)
	);

	mirfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_status (q_status),
		.q_cmd    (pop_cmd),
		.pop      (pop),
		.results  (results)
	);

	// A result without a button must show the 'F' pattern.
	`MIRFD_ASSERT_IMP(a_no_button_shows_f, results.valid && (results.button == mirfd_pkg::BTN_NONE), results.segments == mirfd_pkg::SEG_NONE)
	// A matched button never shows the 'F' pattern.
	`MIRFD_ASSERT_IMP(a_button_shows_digit, results.valid && (results.button != mirfd_pkg::BTN_NONE), results.segments != mirfd_pkg::SEG_NONE)
	// A new result only appears after a queued command was taken.
	`MIRFD_ASSERT_IMP(a_result_from_queue, $rose(results.valid), $past(!q_status.empty))

endmodule

[hdl/mirfd_front.sv]
// Front end: sample slicing, Manchester bit recovery and frame tracking.
module mirfd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mirfd_pkg::cfg_t       cfg,
	input  mirfd_pkg::q_status_t  q_status,
	mirfd_sample_if.sink          samples,
	output logic                  push,
	output mirfd_pkg::cmd_t       push_cmd
);

	logic [mirfd_pkg::POS_W-1:0] pos_q;
	logic                        phase_q;
	logic                        first_q;
	logic [mirfd_pkg::FB_W-1:0]  bits_q;

	logic                        accept;
	logic                        high;
	logic                        bit_val;
	logic [mirfd_pkg::FB_W-1:0]  bits_shift;
	logic [mirfd_pkg::FB_W-1:0]  bits_next;

	assign samples.ready = !q_status.full;
	assign accept        = samples.valid && samples.ready;
	assign high          = (samples.sample >= cfg.threshold);
	assign bit_val       = !first_q;

	// Start bits do not enter the shift register.
	always_comb begin
		bits_shift = mirfd_pkg::FB_W'({bits_q, bit_val});
		if (pos_q <= mirfd_pkg::POS_W'(mirfd_pkg::START_BITS)) begin
			bits_next = bits_q;
		end else begin
			bits_next = bits_shift;
		end
	end

	assign push_cmd = bits_next[mirfd_pkg::COMMAND_BITS-1:0];
	assign push = accept && (pos_q != '0) && phase_q && (high != first_q)
		&& (pos_q >= mirfd_pkg::POS_W'(mirfd_pkg::FRAME_TOTAL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= 1'b0;
			first_q <= 1'b0;
			bits_q  <= '0;
		end else if (accept) begin
			if (pos_q == '0) begin
				if (!high) begin
					pos_q   <= mirfd_pkg::POS_W'(1);
					phase_q <= 1'b1;
					first_q <= 1'b0;
					bits_q  <= '0;
				end
			end else if (!phase_q) begin
				first_q <= high;
				phase_q <= 1'b1;
			end else if ((high == first_q)
				|| ((pos_q <= mirfd_pkg::POS_W'(mirfd_pkg::START_BITS)) && !bit_val)
				|| ((pos_q == mirfd_pkg::POS_W'(mirfd_pkg::START_BITS + mirfd_pkg::ADDRESS_BITS))
					&& (bits_next[mirfd_pkg::ADDRESS_BITS-1:0] != cfg.own_address))
				|| (pos_q >= mirfd_pkg::POS_W'(mirfd_pkg::FRAME_TOTAL))) begin
				// Bit error, bad start, wrong address or finished frame.
				pos_q   <= '0;
				phase_q <= 1'b0;
				first_q <= 1'b0;
				bits_q  <= '0;
			end else begin
				phase_q <= 1'b0;
				pos_q   <= pos_q + mirfd_pkg::POS_W'(1);
				if (pos_q == mirfd_pkg::POS_W'(mirfd_pkg::START_BITS + mirfd_pkg::ADDRESS_BITS)) begin
					bits_q <= '0;
				end else begin
					bits_q <= bits_next;
				end
			end
		end
	end

endmodule

[hdl/mirfd_queue.sv]
// Small command queue that decouples the frame tracker from the result stage.
module mirfd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mirfd_pkg::cmd_t       push_cmd,
	input  logic                  pop,
	output mirfd_pkg::cmd_t       pop_cmd,
	output mirfd_pkg::q_status_t  status
);

	mirfd_pkg::cmd_t                 mem_q [mirfd_pkg::QUEUE_DEPTH];
	logic [mirfd_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [mirfd_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [mirfd_pkg::QCNT_W-1:0]    count_q;

	assign status.full  = (count_q == mirfd_pkg::QCNT_W'(mirfd_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_cmd      = mem_q[rd_ptr_q];

	function automatic logic [mirfd_pkg::QPTR_W-1:0] ptr_inc(
		input logic [mirfd_pkg::QPTR_W-1:0] p
	);
		if (p == mirfd_pkg::QPTR_W'(mirfd_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + mirfd_pkg::QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + mirfd_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - mirfd_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[hdl/mirfd_back.sv]
// Back end: button code lookup and the registered result stage.
module mirfd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mirfd_pkg::cfg_t       cfg,
	input  mirfd_pkg::q_status_t  q_status,
	input  mirfd_pkg::cmd_t       q_cmd,
	output logic                  pop,
	mirfd_result_if.source        results
);

	logic                           valid_q;
	logic [mirfd_pkg::SEG_W-1:0]    seg_q;
	logic [mirfd_pkg::BTN_W-1:0]    btn_q;
	logic [mirfd_pkg::SEG_W-1:0]    seg_n;
	logic [mirfd_pkg::BTN_W-1:0]    btn_n;

	// Walk from the highest button down so the lowest matching one wins.
	always_comb begin
		seg_n = mirfd_pkg::SEG_NONE;
		btn_n = mirfd_pkg::BTN_NONE;
		for (int i = mirfd_pkg::NUM_BUTTONS - 1; i >= 0; i--) begin
			if (cfg.button_code[i] == q_cmd) begin
				seg_n = mirfd_pkg::SEG_DIGIT[i];
				btn_n = mirfd_pkg::BTN_W'(i + 1);
			end
		end
	end

	assign pop = !q_status.empty && (!valid_q || results.ready);

	assign results.valid    = valid_q;
	assign results.segments = seg_q;
	assign results.button   = btn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			seg_q <= seg_n;
			btn_q <= btn_n;
		end
	end

endmodule

[tb/sv/mirfd_checker.sv]
// Checker that predicts the decoded button results and compares them with the block.
module mirfd_checker
	import mirfd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic                    sample_valid,
	input  logic                    sample_ready,
	input  logic [SAMPLE_BITS-1:0]  sample,
	input  logic                    result_valid,
	input  logic                    result_ready,
	input  logic [SEG_W-1:0]        segments,
	input  logic [BTN_W-1:0]        button,
	output int                      mismatches,
	output int                      pending
);

	typedef struct packed {
		logic [SEG_W-1:0] segments;
		logic [BTN_W-1:0] button;
	} button_result_t;

	localparam logic [SAMPLE_BITS-1:0]  THRESHOLD_AT_RESET = SAMPLE_BITS'(511);
	localparam logic [ADDRESS_BITS-1:0] ADDRESS_AT_RESET   = ADDRESS_BITS'(1);
	localparam logic [COMMAND_BITS-1:0] CODES_AT_RESET [NUM_BUTTONS] = '{
		COMMAND_BITS'(1), COMMAND_BITS'(2), COMMAND_BITS'(4)};
	localparam logic [SEG_W-1:0] DIGIT_PATTERN [NUM_BUTTONS] = '{7'h06, 7'h5B, 7'h4F};
	localparam logic [SEG_W-1:0] NO_MATCH_PATTERN = 7'h71;
	localparam logic [BTN_W-1:0] NO_BUTTON = '0;

	logic [SAMPLE_BITS-1:0]  threshold;
	logic [ADDRESS_BITS-1:0] own_address;
	logic [COMMAND_BITS-1:0] button_codes [NUM_BUTTONS];

	logic [POS_W-1:0] bit_pos;
	logic             second_half;
	logic             first_level;
	logic [7:0]       frame_bits;

	button_result_t expected_buttons [$];
	button_result_t oldest;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] button result %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic drop_frame();
		bit_pos = '0;
		second_half = 1'b0;
		first_level = 1'b0;
		frame_bits = '0;
	endtask

	// Follows the frame one half-bit at a time and queues the result of a complete frame.
	task automatic track_half_bit(input logic [SAMPLE_BITS-1:0] value);
		logic           level;
		logic           bit_val;
		logic           found;
		button_result_t res;
		level = (value >= threshold);
		if (bit_pos == 0) begin
			if (!level) begin
				bit_pos = POS_W'(1);
				second_half = 1'b1;
				first_level = 1'b0;
				frame_bits = '0;
			end
			return;
		end
		if (!second_half) begin
			first_level = level;
			second_half = 1'b1;
			return;
		end
		second_half = 1'b0;
		if (level == first_level) begin
			drop_frame();
			return;
		end
		bit_val = !first_level;
		if (bit_pos <= START_BITS) begin
			if (!bit_val) begin
				drop_frame();
				return;
			end
		end else begin
			frame_bits = {frame_bits[6:0], bit_val};
		end
		if (bit_pos == START_BITS + ADDRESS_BITS) begin
			if (frame_bits[ADDRESS_BITS-1:0] != own_address) begin
				drop_frame();
				return;
			end
			frame_bits = '0;
		end
		if (bit_pos >= FRAME_TOTAL) begin
			res.segments = NO_MATCH_PATTERN;
			res.button = NO_BUTTON;
			found = 1'b0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (!found && button_codes[i] == frame_bits[COMMAND_BITS-1:0]) begin
					res.segments = DIGIT_PATTERN[i];
					res.button = BTN_W'(i + 1);
					found = 1'b1;
				end
			end
			expected_buttons.push_back(res);
			drop_frame();
			return;
		end
		bit_pos = bit_pos + 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold = THRESHOLD_AT_RESET;
			own_address = ADDRESS_AT_RESET;
			button_codes = CODES_AT_RESET;
			drop_frame();
			expected_buttons.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (expected_buttons.size() == 0) begin
					report_mismatch("with nothing pending, button", button, -1);
				end else begin
					oldest = expected_buttons.pop_front();
					if (segments !== oldest.segments)
						report_mismatch("segments", segments, oldest.segments);
					if (button !== oldest.button)
						report_mismatch("button", button, oldest.button);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_THRESHOLD:   threshold = cfg_wdata;
					CFG_OWN_ADDRESS: own_address = cfg_wdata[ADDRESS_BITS-1:0];
					CFG_BUTTON1:     button_codes[0] = cfg_wdata[COMMAND_BITS-1:0];
					CFG_BUTTON2:     button_codes[1] = cfg_wdata[COMMAND_BITS-1:0];
					CFG_BUTTON3:     button_codes[2] = cfg_wdata[COMMAND_BITS-1:0];
					default: ;
				endcase
			end
			if (sample_valid && sample_ready)
				track_half_bit(sample);
		end
		pending = expected_buttons.size();
	end

endmodule

[tb/sv/manchester_ir_frame_decoder_top_test.sv]
// Stimulus and verdict for the Manchester IR frame decoder, with the checker beside it.
module manchester_ir_frame_decoder_top_test;
	import mirfd_pkg::*;

	// The run is bounded by a cycle count far above the slowest correct run.
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_ITEMS  = 1950;
	localparam int PHASES        = 8;
	localparam int PRESSURE_PHASE = 2;
	localparam int LONG_HOLD     = 600;
	// Idle time added in settle() once every expected result has been taken.
	localparam int SETTLE_CYCLES = 6;
	localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

	typedef enum int {
		FAULT_NONE,
		FAULT_HALVES_EQUAL,
		FAULT_START_ZERO,
		FAULT_FOREIGN_ADDR
	} frame_fault_e;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_wdata;

	mirfd_sample_if samples ();
	mirfd_result_if results ();

	int mismatches;
	int pending;
	int cycles = 0;
	int items_sent = 0;

	// Handshake pacing knobs for the sample sender and the result receiver.
	bit sender_steady = 1'b0;
	bit receiver_steady = 1'b0;
	bit hold_request = 1'b0;

	// Current register settings, kept to shape the sample levels, addresses and commands.
	logic [SAMPLE_BITS-1:0]  threshold_now;
	logic [ADDRESS_BITS-1:0] address_now;
	logic [COMMAND_BITS-1:0] codes_now [NUM_BUTTONS];

	manchester_ir_frame_decoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.samples   (samples),
		.results   (results)
	);

	mirfd_checker i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.sample_valid (samples.valid),
		.sample_ready (samples.ready),
		.sample       (samples.sample),
		.result_valid (results.valid),
		.result_ready (results.ready),
		.segments     (results.segments),
		.button       (results.button),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Idle gaps: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// The receiver side. It stalls at random, and once per run it holds off for a
	// long stretch so that the result stage and the command queue fill and the
	// block has to drop samples.ready. Exactly one assignment to ready per cycle.
	initial begin
		int stall_left;
		stall_left = 0;
		results.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				results.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LONG_HOLD - 1;
				results.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				results.ready <= 1'b0;
			end else begin
				stall_left = receiver_steady ? 0 : pick_gap();
				results.ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Offers one sample and returns at the falling edge after its transaction.
	// Valid stays high between back-to-back samples.
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
		int gap;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples.valid <= 1'b1;
		samples.sample <= value;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// A sample that the decoder can act on; idle filler goes through send_sample.
	task automatic send_item(input logic [SAMPLE_BITS-1:0] value);
		send_sample(value);
		items_sent++;
	endtask

	// Levels cluster at the threshold edge: one below reads as IR on, the
	// threshold itself reads as off.
	function automatic logic [SAMPLE_BITS-1:0] low_level();
		int r;
		if (threshold_now == 0) return '0;
		r = $urandom_range(0, 99);
		if (r < 15) return threshold_now - 1'b1;
		if (r < 25) return '0;
		return SAMPLE_BITS'($urandom_range(0, threshold_now - 1));
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] high_level();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) return threshold_now;
		if (r < 25) return FULL_SCALE;
		return SAMPLE_BITS'($urandom_range(threshold_now, FULL_SCALE));
	endfunction

	task automatic send_half(input logic level);
		send_item(level ? high_level() : low_level());
	endtask

	// Sends one frame: two start bits of one, the address and the command, MSB
	// first, each bit as low-then-high for one or high-then-low for zero. A frame
	// with equal halves or a zero start bit stops right after the bit that breaks it.
	task automatic send_frame(input logic [ADDRESS_BITS-1:0] addr,
			input logic [COMMAND_BITS-1:0] cmd, input frame_fault_e fault);
		logic [FRAME_TOTAL-1:0] bits;
		int                     bad_bit;
		logic                   level;
		if (fault == FAULT_FOREIGN_ADDR)
			addr = addr ^ ADDRESS_BITS'($urandom_range(1, (1 << ADDRESS_BITS) - 1));
		bits = {2'b11, addr, cmd};
		bad_bit = FRAME_TOTAL;
		case (fault)
			FAULT_HALVES_EQUAL: bad_bit = $urandom_range(0, FRAME_TOTAL - 1);
			FAULT_START_ZERO: begin
				bad_bit = $urandom_range(0, START_BITS - 1);
				bits[FRAME_TOTAL - 1 - bad_bit] = 1'b0;
			end
			default: ;
		endcase
		for (int i = 0; i < FRAME_TOTAL; i++) begin
			if (fault == FAULT_HALVES_EQUAL && i == bad_bit) begin
				level = $urandom_range(0, 1);
				send_half(level);
				send_half(level);
				return;
			end
			send_half(!bits[FRAME_TOTAL - 1 - i]);
			send_half(bits[FRAME_TOTAL - 1 - i]);
			if (i == bad_bit)
				return;
		end
	endtask

	function automatic logic [COMMAND_BITS-1:0] pick_command();
		if ($urandom_range(0, 99) < 60)
			return codes_now[$urandom_range(0, NUM_BUTTONS - 1)];
		return COMMAND_BITS'($urandom);
	endfunction

	// Brings the decoder back to idle and waits until every expected result has
	// been taken. Three full-scale samples end any partial frame: either a bit
	// error or, at worst, the completion of a frame that is then predicted.
	task automatic settle();
		repeat (3) send_sample(FULL_SCALE);
		samples.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write per cycle; the caller lowers cfg_we after the last one.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	// Writes every register. The narrow ones get random junk above their field,
	// which the block has to discard.
	task automatic program_registers(input logic [SAMPLE_BITS-1:0] thr,
			input logic [ADDRESS_BITS-1:0] addr, input logic [COMMAND_BITS-1:0] c1,
			input logic [COMMAND_BITS-1:0] c2, input logic [COMMAND_BITS-1:0] c3);
		logic [CFG_W-1:0] junk;
		write_reg(CFG_THRESHOLD, thr);
		junk = CFG_W'($urandom);
		write_reg(CFG_OWN_ADDRESS, {junk[CFG_W-1:ADDRESS_BITS], addr});
		junk = CFG_W'($urandom);
		write_reg(CFG_BUTTON1, {junk[CFG_W-1:COMMAND_BITS], c1});
		junk = CFG_W'($urandom);
		write_reg(CFG_BUTTON2, {junk[CFG_W-1:COMMAND_BITS], c2});
		junk = CFG_W'($urandom);
		write_reg(CFG_BUTTON3, {junk[CFG_W-1:COMMAND_BITS], c3});
		cfg_we <= 1'b0;
		threshold_now = thr;
		address_now = addr;
		codes_now[0] = c1;
		codes_now[1] = c2;
		codes_now[2] = c3;
	endtask

	initial begin
		logic [FRAME_TOTAL-1:0]  bits;
		logic [SAMPLE_BITS-1:0]  thr;
		logic [ADDRESS_BITS-1:0] addr;
		logic [COMMAND_BITS-1:0] c1;
		logic [COMMAND_BITS-1:0] c2;
		logic [COMMAND_BITS-1:0] c3;
		int                      phase_end;
		int                      r;
		bit                      resync;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		samples.valid = 1'b0;
		samples.sample = '0;
		threshold_now = SAMPLE_BITS'(511);
		address_now = ADDRESS_BITS'(1);
		codes_now = '{COMMAND_BITS'(1), COMMAND_BITS'(2), COMMAND_BITS'(4)};
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, on the reset settings. A high sample while idle is ignored.
		send_item(FULL_SCALE);
		// A clean frame for address 1, command 2: lows at zero and one below the
		// threshold, highs at full scale and at the threshold itself.
		bits = {2'b11, ADDRESS_BITS'(1), COMMAND_BITS'(2)};
		for (int i = 0; i < FRAME_TOTAL; i++) begin
			if (bits[FRAME_TOTAL - 1 - i]) begin
				send_item(i[0] ? threshold_now - 1'b1 : '0);
				send_item(i[0] ? threshold_now : FULL_SCALE);
			end else begin
				send_item(i[0] ? threshold_now : FULL_SCALE);
				send_item(i[0] ? threshold_now - 1'b1 : '0);
			end
		end
		// A second start bit of zero drops the frame.
		send_item('0);
		send_item(FULL_SCALE);
		send_item(FULL_SCALE);
		send_item('0);
		// Two equal halves are a bit error.
		send_item('0);
		send_item('0);
		// With the threshold at zero nothing ever reads as IR on.
		settle();
		program_registers('0, address_now, codes_now[0], codes_now[1], codes_now[2]);
		send_item('0);
		send_item(FULL_SCALE);
		send_item('0);

		// Random part, in phases with different settings. Each phase starts with
		// the sender paused until every expected result has come back.
		for (int p = 0; p < PHASES; p++) begin
			phase_end = items_sent + RANDOM_ITEMS / PHASES;
			settle();
			case (p)
				0: begin
					thr = FULL_SCALE;
					addr = '1;
					c1 = '1;
					c2 = '1;
					c3 = '1;
				end
				1: begin
					thr = SAMPLE_BITS'(1);
					addr = '0;
					c1 = '0;
					c2 = '0;
					c3 = COMMAND_BITS'($urandom);
				end
				default: begin
					thr = SAMPLE_BITS'($urandom_range(1, FULL_SCALE));
					addr = ADDRESS_BITS'($urandom);
					c1 = COMMAND_BITS'($urandom);
					c2 = ($urandom_range(0, 3) == 0) ? c1 : COMMAND_BITS'($urandom);
					c3 = ($urandom_range(0, 3) == 0) ? c2 : COMMAND_BITS'($urandom);
				end
			endcase
			program_registers(thr, addr, c1, c2, c3);

			// The pressure phase streams samples without gaps while the receiver
			// is held off; other phases sometimes run without idling on one side.
			sender_steady = (p == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
			receiver_steady = ($urandom_range(0, 3) == 0);
			if (p == PRESSURE_PHASE)
				hold_request = 1'b1;

			resync = 1'b1;
			while (items_sent < phase_end) begin
				// After anything but a clean frame, full-scale filler forces idle
				// so that the next frame is decoded from its start.
				if (resync)
					repeat (3) send_sample(FULL_SCALE);
				else
					repeat ($urandom_range(0, 1)) send_sample(high_level());
				resync = 1'b1;
				r = $urandom_range(0, 99);
				if (r < 70) begin
					send_frame(address_now, pick_command(), FAULT_NONE);
					resync = 1'b0;
				end else if (r < 78) begin
					send_frame(address_now, pick_command(), FAULT_FOREIGN_ADDR);
				end else if (r < 88) begin
					send_frame(address_now, pick_command(), FAULT_HALVES_EQUAL);
				end else if (r < 94) begin
					send_frame(address_now, pick_command(), FAULT_START_ZERO);
				end else begin
					repeat ($urandom_range(1, 8)) send_item(SAMPLE_BITS'($urandom));
				end
			end
			sender_steady = 1'b0;
			receiver_steady = 1'b0;
		end

		// Drain, then give the verdict.
		settle();
		if (mismatches == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
